### src/tmln_pkg.sv
// ----------------------------------------------------------------------------
// tmln_pkg: shared constants for the trimmed mean level normalizer
// Field widths, register indexes, reset values and scaling constants.
// ----------------------------------------------------------------------------
package tmln_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CHAN_BITS       = 3;
  localparam int LEVEL_BITS      = 7;
  localparam int NUM_SAMPLES     = 5;
  localparam int KEPT            = 3;
  localparam int FULL_SCALE      = 100;

  localparam int LOW_RESET  = 200;
  localparam int HIGH_RESET = 1000;

  // Two index bits, so that a write to an index past the last register
  // reaches the block and is ignored there.
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_LOW  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HIGH = 2'd1;

endpackage

### src/tmln_in_if.sv
// ----------------------------------------------------------------------------
// tmln_in_if: sample group channel
// Carries one channel number and five raw converter samples per request.
// ----------------------------------------------------------------------------
interface tmln_in_if #(
  parameter int SAMPLE_BITS = tmln_pkg::SAMPLE_BITS_DEF
) ();
  import tmln_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CHAN_BITS-1:0]   channel;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic [SAMPLE_BITS-1:0] sample_b;
  logic [SAMPLE_BITS-1:0] sample_c;
  logic [SAMPLE_BITS-1:0] sample_d;
  logic [SAMPLE_BITS-1:0] sample_e;

  modport source (
    output valid, channel, sample_a, sample_b, sample_c, sample_d, sample_e,
    input  ready
  );

  modport sink (
    input  valid, channel, sample_a, sample_b, sample_c, sample_d, sample_e,
    output ready
  );
endinterface

### src/tmln_out_if.sv
// ----------------------------------------------------------------------------
// tmln_out_if: normalized level channel
// Carries the echoed channel, the trimmed mean, the level and the range flag.
// ----------------------------------------------------------------------------
interface tmln_out_if #(
  parameter int SAMPLE_BITS = tmln_pkg::SAMPLE_BITS_DEF
) ();
  import tmln_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CHAN_BITS-1:0]   channel_out;
  logic [SAMPLE_BITS-1:0] mean_value;
  logic [LEVEL_BITS-1:0]  level;
  logic                   range_bad;

  modport source (
    output valid, channel_out, mean_value, level, range_bad,
    input  ready
  );

  modport sink (
    input  valid, channel_out, mean_value, level, range_bad,
    output ready
  );
endinterface

### src/tmln_trim.sv
// ----------------------------------------------------------------------------
// tmln_trim: three-stage trimmed mean of five samples
// Sum, minimum and maximum, then the middle-three sum, then division by
// three through a reciprocal multiply.
// ----------------------------------------------------------------------------
module tmln_trim #(
  parameter int SAMPLE_BITS = tmln_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic [tmln_pkg::CHAN_BITS-1:0]                      in_channel,
  input  logic [tmln_pkg::NUM_SAMPLES-1:0][SAMPLE_BITS-1:0]   in_samples,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic [tmln_pkg::CHAN_BITS-1:0]                      out_channel,
  output logic [SAMPLE_BITS-1:0]                              out_mean
);
  import tmln_pkg::*;

  localparam int SUM_BITS  = SAMPLE_BITS + 3;
  localparam int MID_BITS  = SAMPLE_BITS + 2;
  localparam int SHIFT     = MID_BITS + 1;
  localparam int MUL_BITS  = MID_BITS;
  localparam int PROD_BITS = MID_BITS + MUL_BITS;
  // Rounded-up reciprocal of three; exact for every middle-three sum.
  localparam int RECIP     = ((1 << SHIFT) + KEPT - 1) / KEPT;
  localparam logic [MUL_BITS-1:0] RECIP_V = MUL_BITS'(RECIP);

  logic                   s1_v, s2_v, s3_v;
  logic                   s1_rdy, s2_rdy, s3_rdy;
  logic [CHAN_BITS-1:0]   s1_chan, s2_chan, s3_chan;
  logic [SUM_BITS-1:0]    s1_sum;
  logic [SAMPLE_BITS-1:0] s1_min, s1_max;
  logic [MID_BITS-1:0]    s2_mid;
  logic [SAMPLE_BITS-1:0] s3_mean;

  logic [SUM_BITS-1:0]    sum_c;
  logic [SAMPLE_BITS-1:0] min_c, max_c;
  logic [SUM_BITS-1:0]    mid_c;
  logic [PROD_BITS-1:0]   prod_c;

  always_comb begin
    sum_c = '0;
    min_c = in_samples[0];
    max_c = in_samples[0];
    for (int i = 1; i < NUM_SAMPLES; i++) begin
      if (in_samples[i] < min_c) begin
        min_c = in_samples[i];
      end
      if (in_samples[i] > max_c) begin
        max_c = in_samples[i];
      end
    end
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      sum_c = sum_c + SUM_BITS'(in_samples[i]);
    end
  end

  assign mid_c  = s1_sum - SUM_BITS'(s1_min) - SUM_BITS'(s1_max);
  assign prod_c = PROD_BITS'(s2_mid) * PROD_BITS'(RECIP_V);

  assign s3_rdy   = !s3_v || out_ready;
  assign s2_rdy   = !s2_v || s3_rdy;
  assign s1_rdy   = !s1_v || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v <= in_valid;
      end
      if (s2_rdy) begin
        s2_v <= s1_v;
      end
      if (s3_rdy) begin
        s3_v <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_chan <= in_channel;
      s1_sum  <= sum_c;
      s1_min  <= min_c;
      s1_max  <= max_c;
    end
    if (s2_rdy && s1_v) begin
      s2_chan <= s1_chan;
      s2_mid  <= mid_c[MID_BITS-1:0];
    end
    if (s3_rdy && s2_v) begin
      s3_chan <= s2_chan;
      s3_mean <= prod_c[SHIFT +: SAMPLE_BITS];
    end
  end

  assign out_valid   = s3_v;
  assign out_channel = s3_chan;
  assign out_mean    = s3_mean;
endmodule

### src/tmln_div.sv
// ----------------------------------------------------------------------------
// tmln_div: pipelined restoring divider
// One quotient bit per stage; the numerator must stay below the
// denominator shifted by the quotient width.
// ----------------------------------------------------------------------------
module tmln_div #(
  parameter int NUM_BITS  = tmln_pkg::SAMPLE_BITS_DEF + tmln_pkg::LEVEL_BITS,
  parameter int DEN_BITS  = tmln_pkg::SAMPLE_BITS_DEF,
  parameter int Q_BITS    = tmln_pkg::LEVEL_BITS,
  parameter int SIDE_BITS = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_BITS-1:0]  in_num,
  input  logic [DEN_BITS-1:0]  in_den,
  input  logic [SIDE_BITS-1:0] in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [Q_BITS-1:0]    out_q,
  output logic [SIDE_BITS-1:0] out_side
);
  import tmln_pkg::*;

  logic [Q_BITS-1:0]                v;
  logic [Q_BITS-1:0]                rdy;
  logic [Q_BITS-1:0][NUM_BITS-1:0]  rem;
  logic [Q_BITS-1:0][DEN_BITS-1:0]  den;
  logic [Q_BITS-1:0][Q_BITS-1:0]    quo;
  logic [Q_BITS-1:0][SIDE_BITS-1:0] side;

  genvar k;
  generate
    for (k = 0; k < Q_BITS; k++) begin : g_stage
      localparam int BIT = Q_BITS - 1 - k;

      logic                 up_v;
      logic [NUM_BITS-1:0]  up_rem;
      logic [DEN_BITS-1:0]  up_den;
      logic [Q_BITS-1:0]    up_quo;
      logic [SIDE_BITS-1:0] up_side;
      logic                 down_rdy;
      logic [NUM_BITS-1:0]  trial;
      logic                 fits;

      if (k == 0) begin : g_first
        assign up_v    = in_valid;
        assign up_rem  = in_num;
        assign up_den  = in_den;
        assign up_quo  = '0;
        assign up_side = in_side;
      end else begin : g_rest
        assign up_v    = v[k-1];
        assign up_rem  = rem[k-1];
        assign up_den  = den[k-1];
        assign up_quo  = quo[k-1];
        assign up_side = side[k-1];
      end

      if (k == Q_BITS - 1) begin : g_last
        assign down_rdy = out_ready;
      end else begin : g_mid
        assign down_rdy = rdy[k+1];
      end

      assign rdy[k] = !v[k] || down_rdy;
      assign trial  = NUM_BITS'(up_den) << BIT;
      assign fits   = (up_rem >= trial);

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (rdy[k]) begin
          v[k] <= up_v;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && up_v) begin
          rem[k]  <= fits ? (up_rem - trial) : up_rem;
          den[k]  <= up_den;
          quo[k]  <= up_quo | (Q_BITS'(fits) << BIT);
          side[k] <= up_side;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v[Q_BITS-1];
  assign out_q     = quo[Q_BITS-1];
  assign out_side  = side[Q_BITS-1];
endmodule

### src/trimmed_mean_level_normalizer.sv
// ----------------------------------------------------------------------------
// trimmed_mean_level_normalizer: trimmed mean and percent level of a channel
// Averages the middle three of five samples and scales the mean between
// two configured levels to a clamped whole percent.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle when the output side does not
// stall and returns one result for each, in order. The path is a twelve-stage
// pipeline: three stages form the trimmed mean, two clamp and scale the offset
// from the low level, and seven stages of the restoring divider each produce
// one bit of the level. Every stage has its own valid bit and holds its
// contents while the stage after it is full and stalled. The ready path runs
// combinationally from the output back to the input, so empty stages keep
// filling during an output stall and the request side is held in the same
// cycle once every stage is full; no request is dropped or repeated. The low
// and high levels are written through the plain write port and must only
// change while the pipeline is empty. When the high level is not above the
// low level, the level reads zero and range_bad is set; the mean is still
// given.
// ----------------------------------------------------------------------------
module trimmed_mean_level_normalizer #(
  parameter int SAMPLE_BITS = tmln_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  tmln_in_if.sink                           samples,
  tmln_out_if.source                        results,
  input  logic                              wr_en,
  input  logic [tmln_pkg::REG_IDX_BITS-1:0] wr_index,
  input  logic [SAMPLE_BITS-1:0]            wr_data
);
  import tmln_pkg::*;

  localparam int NUM_BITS  = SAMPLE_BITS + LEVEL_BITS;
  localparam int SIDE_BITS = CHAN_BITS + SAMPLE_BITS + 1;

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] low_level;
  logic [SAMPLE_BITS-1:0] high_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level  <= SAMPLE_BITS'(LOW_RESET);
      high_level <= SAMPLE_BITS'(HIGH_RESET);
    end else if (wr_en) begin
      case (wr_index)
        REG_LOW:  low_level  <= wr_data;
        REG_HIGH: high_level <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Trimmed mean: stages one to three.
  logic [NUM_SAMPLES-1:0][SAMPLE_BITS-1:0] in_samples;
  logic                   tr_valid, tr_ready;
  logic [CHAN_BITS-1:0]   tr_chan;
  logic [SAMPLE_BITS-1:0] tr_mean;

  assign in_samples[0] = samples.sample_a;
  assign in_samples[1] = samples.sample_b;
  assign in_samples[2] = samples.sample_c;
  assign in_samples[3] = samples.sample_d;
  assign in_samples[4] = samples.sample_e;

  tmln_trim #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_trim (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .in_channel (samples.channel),
    .in_samples (in_samples),
    .out_valid  (tr_valid),
    .out_ready  (tr_ready),
    .out_channel(tr_chan),
    .out_mean   (tr_mean)
  );

  // Stage four clamps the mean into the configured window and keeps the
  // offset from the low level. A bad range forces a zero offset over a
  // denominator of one, so the divider returns zero. A mean at or above the
  // high level gives the full window, which divides to exactly one hundred.
  logic                   n1_v, n1_rdy;
  logic [SAMPLE_BITS-1:0] n1_off;
  logic [SAMPLE_BITS-1:0] n1_den;
  logic [SIDE_BITS-1:0]   n1_side;

  logic                   bad_c;
  logic [SAMPLE_BITS-1:0] span_c;
  logic [SAMPLE_BITS-1:0] off_c;
  logic [SAMPLE_BITS-1:0] den_c;

  always_comb begin
    bad_c  = (high_level <= low_level);
    span_c = high_level - low_level;
    if (bad_c || (tr_mean <= low_level)) begin
      off_c = '0;
    end else if (tr_mean >= high_level) begin
      off_c = span_c;
    end else begin
      off_c = tr_mean - low_level;
    end
    den_c = bad_c ? SAMPLE_BITS'(1) : span_c;
  end

  // Stage five scales the offset to percent; the numerator stays at most
  // one hundred times the denominator, inside the divider's quotient range.
  logic                 n2_v, n2_rdy;
  logic [NUM_BITS-1:0]  n2_num;
  logic [SAMPLE_BITS-1:0] n2_den;
  logic [SIDE_BITS-1:0] n2_side;

  logic                 dv_ready;

  assign n2_rdy   = !n2_v || dv_ready;
  assign n1_rdy   = !n1_v || n2_rdy;
  assign tr_ready = n1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
      n2_v <= 1'b0;
    end else begin
      if (n1_rdy) begin
        n1_v <= tr_valid;
      end
      if (n2_rdy) begin
        n2_v <= n1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n1_rdy && tr_valid) begin
      n1_off  <= off_c;
      n1_den  <= den_c;
      n1_side <= {tr_chan, tr_mean, bad_c};
    end
    if (n2_rdy && n1_v) begin
      n2_num  <= NUM_BITS'(n1_off) * NUM_BITS'(FULL_SCALE);
      n2_den  <= n1_den;
      n2_side <= n1_side;
    end
  end

  // Stages six to twelve: one level bit per stage. The last divider stage
  // is the output register.
  logic [LEVEL_BITS-1:0] dv_q;
  logic [SIDE_BITS-1:0]  dv_side;

  tmln_div #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (SAMPLE_BITS),
    .Q_BITS   (LEVEL_BITS),
    .SIDE_BITS(SIDE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (n2_v),
    .in_ready (dv_ready),
    .in_num   (n2_num),
    .in_den   (n2_den),
    .in_side  (n2_side),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  assign results.level       = dv_q;
  assign results.channel_out = dv_side[SIDE_BITS-1 -: CHAN_BITS];
  assign results.mean_value  = dv_side[SAMPLE_BITS:1];
  assign results.range_bad   = dv_side[0];
endmodule
